FILE: hw/rtl/pbtm_pkg.sv
// Shared types and constants for the paged block table manager.
// No dependencies; imported by the top level and its checker.
package pbtm_pkg;

    localparam int PHYS_W    = 10;
    localparam int LEN_W     = 15;
    localparam int CNT_OUT_W = 7;
    localparam int FREE_W    = 11;
    localparam int SID_W     = 6;
    localparam int LB_W      = 6;
    localparam int BSIZE_W   = 9;

    localparam int DEF_POOL_BLOCKS   = 1024;
    localparam int DEF_NUM_SEQUENCES = 64;
    localparam int DEF_MAX_BLOCKS    = 64;

    localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(16);
    localparam logic [LEN_W-1:0]   LEN_LIMIT   = LEN_W'(32767);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_BLOCKS  = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NO_SEQ     = 3'd3,
        ST_PAST_END   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_DEC,
        S_POP,
        S_LOOK,
        S_FREE
    } t_state;

endpackage

FILE: hw/rtl/paged_block_table_manager_top.sv
// Paged block table manager: free stack of physical blocks plus per-sequence tables.
// Depends on pbtm_pkg.
//
// Usage: raise start with op, sequence_id and logical_block; the request is taken
// when start is high and busy is low. Exactly one result follows per request,
// shown for one cycle with o_done high; the receiver cannot stall it.
// The block size is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// Append computes one remainder bit per cycle over the 15-bit length, then,
// when a block is needed, does a read-modify-write of the free stack.
// Free reads one block table entry per cycle; the push of each entry comes
// in the cycle after its read.
// One request is in flight at a time; busy is already low in the o_done cycle,
// so the next request may be taken at the edge that takes the result.
// State lives in three synchronous memories (sequence records, block table,
// free stack). Reset clears sequence valid bits and sets the stack pointer and its
// low-water mark to POOL_BLOCKS; stack entries never overwritten read as their reset
// value, so no clearing pass is needed and requests are taken right after reset.
module paged_block_table_manager_top #(
    parameter int POOL_BLOCKS             = pbtm_pkg::DEF_POOL_BLOCKS,
    parameter int NUM_SEQUENCES           = pbtm_pkg::DEF_NUM_SEQUENCES,
    parameter int MAX_BLOCKS_PER_SEQUENCE = pbtm_pkg::DEF_MAX_BLOCKS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbtm_pkg::BSIZE_W-1:0]    i_cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  pbtm_pkg::t_op                   i_op,
    input  logic [pbtm_pkg::SID_W-1:0]      i_sequence_id,
    input  logic [pbtm_pkg::LB_W-1:0]       i_logical_block,
    output logic                            o_done,
    output pbtm_pkg::t_status               o_status,
    output logic [pbtm_pkg::PHYS_W-1:0]     o_physical_block,
    output logic [pbtm_pkg::LEN_W-1:0]      o_tokens_in_sequence,
    output logic [pbtm_pkg::CNT_OUT_W-1:0]  o_blocks_in_sequence,
    output logic [pbtm_pkg::FREE_W-1:0]     o_free_blocks
);
    import pbtm_pkg::*;

    localparam int BLK_W     = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int TOP_W     = $clog2(POOL_BLOCKS + 1);
    localparam int SEQ_W     = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
    localparam int CNT_W     = $clog2(MAX_BLOCKS_PER_SEQUENCE + 1);
    localparam int MAP_DEPTH = NUM_SEQUENCES * MAX_BLOCKS_PER_SEQUENCE;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int REC_W     = LEN_W + CNT_W;

    // Memories
    logic [REC_W-1:0] seq_mem [NUM_SEQUENCES];
    logic [BLK_W-1:0] map_mem [MAP_DEPTH];
    logic [BLK_W-1:0] stk_mem [POOL_BLOCKS];

    logic [REC_W-1:0]         r_seq_rd;
    logic [BLK_W-1:0]         r_map_rd;
    logic [BLK_W-1:0]         r_stk_rd;
    logic [BLK_W-1:0]         r_stk_ival;
    logic                     r_stk_init;
    logic [NUM_SEQUENCES-1:0] r_seq_vld;
    logic                     r_vld_rd;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [SEQ_W-1:0]       r_sid;
    logic                   r_sid_ok;
    logic [LB_W-1:0]        r_lb;
    logic [LEN_W-1:0]       r_len;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_k;
    logic                   r_push_pend;
    logic [TOP_W-1:0]       r_top, n_top;
    logic [TOP_W-1:0]       r_min_top;
    logic [BSIZE_W-1:0]     r_bsize;
    logic [BSIZE_W-1:0]     r_rem;
    logic [3:0]             r_bit;

    logic                   r_done;
    t_status                r_o_status;
    logic [BLK_W-1:0]       r_o_phys;
    logic [LEN_W-1:0]       r_o_len;
    logic [CNT_W-1:0]       r_o_cnt;
    logic [TOP_W-1:0]       r_o_free;

    // Combinational control
    logic [LEN_W-1:0]   ev_len;
    logic [CNT_W-1:0]   ev_cnt;
    logic [BSIZE_W-1:0] bs;
    logic [BSIZE_W:0]   trial;
    logic [BSIZE_W:0]   trial_sub;
    logic               need, full, free_done;
    logic [MAP_AW-1:0]  base;
    logic [MAP_AW-1:0]  map_raddr;
    logic [BLK_W-1:0]   pop_phys;
    logic [TOP_W-1:0]   top_m1;

    logic               fin;
    t_status            f_status;
    logic [BLK_W-1:0]   f_phys;
    logic [LEN_W-1:0]   f_len;
    logic [CNT_W-1:0]   f_cnt;
    logic               seq_we, vld_set, vld_clr, map_we, stk_we;

    assign busy   = (r_state != S_IDLE);
    assign ev_len = r_vld_rd ? r_seq_rd[REC_W-1:CNT_W] : '0;
    assign ev_cnt = r_vld_rd ? r_seq_rd[CNT_W-1:0] : '0;
    assign bs     = (r_bsize == '0) ? BSIZE_W'(1) : r_bsize;
    assign trial  = {r_rem, r_len[r_bit]};
    assign trial_sub = trial - {1'b0, bs};
    assign need   = (r_rem == '0);
    assign full   = (r_len >= LEN_LIMIT) ||
                    (need && (32'(r_cnt) >= MAX_BLOCKS_PER_SEQUENCE));
    assign free_done = (r_k >= r_cnt) && !r_push_pend;
    assign base   = MAP_AW'(32'(r_sid) * MAX_BLOCKS_PER_SEQUENCE);
    assign top_m1 = r_top - TOP_W'(1);
    assign pop_phys = r_stk_init ? r_stk_ival : r_stk_rd;
    assign map_raddr = (r_state == S_EVAL) ? base + MAP_AW'(r_lb) : base + MAP_AW'(r_k);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!r_sid_ok) begin
                    n_state = S_IDLE;
                end else begin
                    unique case (r_op)
                        OP_APPEND: n_state = S_DIV;
                        OP_FREE:   n_state = r_vld_rd ? S_FREE : S_IDLE;
                        OP_LOOKUP: n_state = (r_vld_rd && (32'(r_lb) < 32'(ev_cnt)) &&
                                              (32'(r_lb) < MAX_BLOCKS_PER_SEQUENCE))
                                             ? S_LOOK : S_IDLE;
                        OP_NONE:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:  n_state = (r_bit == 4'd0) ? S_DEC : S_DIV;
            S_DEC:  n_state = (!full && need && (r_top != '0)) ? S_POP : S_IDLE;
            S_POP:  n_state = S_IDLE;
            S_LOOK: n_state = S_IDLE;
            S_FREE: n_state = free_done ? S_IDLE : S_FREE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        fin      = 1'b0;
        f_status = ST_OK;
        f_phys   = '0;
        f_len    = r_len;
        f_cnt    = r_cnt;
        seq_we   = 1'b0;
        vld_set  = 1'b0;
        vld_clr  = 1'b0;
        map_we   = 1'b0;
        stk_we   = 1'b0;
        n_top    = r_top;
        unique case (r_state)
            S_EVAL: begin
                f_len = ev_len;
                f_cnt = ev_cnt;
                if (!r_sid_ok) begin
                    fin = 1'b1;
                    f_status = ST_NO_SEQ;
                    f_len = '0;
                    f_cnt = '0;
                end else begin
                    unique case (r_op)
                        OP_APPEND: fin = 1'b0;
                        OP_FREE: begin
                            if (!r_vld_rd) begin
                                fin = 1'b1;
                                f_status = ST_NO_SEQ;
                            end
                        end
                        OP_LOOKUP: begin
                            if (!r_vld_rd) begin
                                fin = 1'b1;
                                f_status = ST_NO_SEQ;
                            end else if ((32'(r_lb) >= 32'(ev_cnt)) ||
                                         (32'(r_lb) >= MAX_BLOCKS_PER_SEQUENCE)) begin
                                fin = 1'b1;
                                f_status = ST_PAST_END;
                            end
                        end
                        OP_NONE: fin = 1'b1;
                    endcase
                end
            end
            S_DEC: begin
                if (full) begin
                    fin = 1'b1;
                    f_status = ST_TABLE_FULL;
                end else if (need && (r_top == '0)) begin
                    fin = 1'b1;
                    f_status = ST_NO_BLOCKS;
                end else if (!need) begin
                    fin = 1'b1;
                    f_len = r_len + LEN_W'(1);
                    seq_we = 1'b1;
                    vld_set = 1'b1;
                end
            end
            S_POP: begin
                fin = 1'b1;
                f_phys = pop_phys;
                f_len = r_len + LEN_W'(1);
                f_cnt = r_cnt + CNT_W'(1);
                seq_we = 1'b1;
                vld_set = 1'b1;
                map_we = 1'b1;
                n_top = top_m1;
            end
            S_LOOK: begin
                fin = 1'b1;
                f_phys = r_map_rd;
            end
            S_FREE: begin
                // push the entry read last cycle; a full stack drops it
                if (r_push_pend && (32'(r_top) < POOL_BLOCKS)) begin
                    stk_we = 1'b1;
                    n_top = r_top + TOP_W'(1);
                end
                if (free_done) begin
                    fin = 1'b1;
                    f_len = '0;
                    f_cnt = '0;
                    vld_clr = 1'b1;
                end
            end
            default: fin = 1'b0;
        endcase
    end

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (seq_we) seq_mem[r_sid] <= {f_len, f_cnt};
        r_seq_rd <= seq_mem[SEQ_W'(i_sequence_id)];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) map_mem[base + MAP_AW'(r_cnt)] <= pop_phys;
        r_map_rd <= map_mem[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) stk_mem[r_top[BLK_W-1:0]] <= r_map_rd;
        r_stk_rd <= stk_mem[top_m1[BLK_W-1:0]];
        // entries below the low-water mark were never overwritten
        r_stk_init <= (r_top <= r_min_top);
        r_stk_ival <= BLK_W'(TOP_W'(POOL_BLOCKS) - r_top);
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seq_vld   <= '0;
            r_top       <= TOP_W'(POOL_BLOCKS);
            r_min_top   <= TOP_W'(POOL_BLOCKS);
            r_bsize     <= BSIZE_RESET;
            r_done      <= 1'b0;
            r_push_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= fin;
            r_top   <= n_top;
            if (n_top < r_min_top) r_min_top <= n_top;
            if (i_cfg_we) r_bsize <= i_cfg_wdata;
            if (vld_set) r_seq_vld[r_sid] <= 1'b1;
            if (vld_clr) r_seq_vld[r_sid] <= 1'b0;
            if (r_state == S_FREE) begin
                r_push_pend <= (r_k < r_cnt);
            end else begin
                r_push_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op     <= i_op;
                r_sid    <= SEQ_W'(i_sequence_id);
                r_sid_ok <= (32'(i_sequence_id) < NUM_SEQUENCES);
                r_lb     <= i_logical_block;
                r_vld_rd <= r_seq_vld[SEQ_W'(i_sequence_id)];
            end
            S_EVAL: begin
                r_len <= ev_len;
                r_cnt <= ev_cnt;
                r_rem <= '0;
                r_bit <= 4'd14;
                r_k   <= '0;
            end
            S_DIV: begin
                // one restoring remainder bit per cycle
                r_rem <= trial_sub[BSIZE_W] ? trial[BSIZE_W-1:0] : trial_sub[BSIZE_W-1:0];
                r_bit <= r_bit - 4'd1;
            end
            S_FREE: begin
                if (r_k < r_cnt) r_k <= r_k + CNT_W'(1);
            end
            default: r_k <= r_k;
        endcase
        if (fin) begin
            r_o_status <= f_status;
            r_o_phys   <= f_phys;
            r_o_len    <= f_len;
            r_o_cnt    <= f_cnt;
            r_o_free   <= n_top;
        end
    end

    assign o_done               = r_done;
    assign o_status             = r_o_status;
    assign o_physical_block     = PHYS_W'(r_o_phys);
    assign o_tokens_in_sequence = r_o_len;
    assign o_blocks_in_sequence = CNT_OUT_W'(r_o_cnt);
    assign o_free_blocks        = FREE_W'(r_o_free);

endmodule

FILE: hw/rtl/pbtm_checker.sv
// Port-level checks for the paged block table manager, bound to its top level.
// Depends on pbtm_pkg and paged_block_table_manager_top.
module pbtm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_done,
    input pbtm_pkg::t_status               o_status,
    input logic [pbtm_pkg::PHYS_W-1:0]     o_physical_block,
    input logic [pbtm_pkg::LEN_W-1:0]      o_tokens_in_sequence,
    input logic [pbtm_pkg::CNT_OUT_W-1:0]  o_blocks_in_sequence
);
    import pbtm_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && !$past(o_done))
        else $error("result shown while busy or for two cycles");

    a_fail_no_phys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_physical_block == '0))
        else $error("failed request returned a block");

    a_noseq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_NO_SEQ) |->
            (o_tokens_in_sequence == '0) && (o_blocks_in_sequence == '0))
        else $error("unknown sequence reported nonzero counts");

endmodule

bind paged_block_table_manager_top pbtm_checker u_pbtm_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for paged_block_table_manager_top.
// Depends on pbtm_pkg and the top level; predicts every result in place and
// compares each done strobe against the oldest expected result.
`timescale 1ns / 100ps

module testbench;
    import pbtm_pkg::*;

    localparam int NBLK = DEF_POOL_BLOCKS;
    localparam int NSEQ = DEF_NUM_SEQUENCES;
    localparam int MAXB = DEF_MAX_BLOCKS;

    typedef struct packed {
        t_status            status;
        logic [PHYS_W-1:0]  phys;
        logic [LEN_W-1:0]   tokens;
        logic [CNT_OUT_W-1:0] blocks;
        logic [FREE_W-1:0]  free_cnt;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [BSIZE_W-1:0]   i_cfg_wdata;
    logic                 start;
    logic                 busy;
    t_op                  i_op;
    logic [SID_W-1:0]     i_sequence_id;
    logic [LB_W-1:0]      i_logical_block;
    logic                 o_done;
    t_status              o_status;
    logic [PHYS_W-1:0]    o_physical_block;
    logic [LEN_W-1:0]     o_tokens_in_sequence;
    logic [CNT_OUT_W-1:0] o_blocks_in_sequence;
    logic [FREE_W-1:0]    o_free_blocks;

    paged_block_table_manager_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .start               (start),
        .busy                (busy),
        .i_op                (i_op),
        .i_sequence_id       (i_sequence_id),
        .i_logical_block     (i_logical_block),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_physical_block    (o_physical_block),
        .o_tokens_in_sequence(o_tokens_in_sequence),
        .o_blocks_in_sequence(o_blocks_in_sequence),
        .o_free_blocks       (o_free_blocks)
    );

    // Mirror of the block state
    logic [PHYS_W-1:0]  pool_stack [NBLK];
    int unsigned        pool_top;
    bit                 seq_live   [NSEQ];
    int unsigned        seq_tokens [NSEQ];
    int unsigned        seq_blocks [NSEQ];
    logic [PHYS_W-1:0]  seq_table  [NSEQ][MAXB];
    int unsigned        blk_tokens;

    t_answer     answers_due[$];
    int unsigned errors;
    int unsigned idle_pct;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic t_answer pack_answer(t_status st, int unsigned phys,
                                            int unsigned len, int unsigned cnt);
        t_answer a;
        a.status   = st;
        a.phys     = PHYS_W'(phys);
        a.tokens   = LEN_W'(len);
        a.blocks   = CNT_OUT_W'(cnt);
        a.free_cnt = FREE_W'(pool_top);
        return a;
    endfunction

    function automatic t_answer predict_request(t_op op, int unsigned sid, int unsigned lb);
        int unsigned bs;
        int unsigned len;
        int unsigned cnt;
        int unsigned phys;
        bit          need;
        bs   = (blk_tokens == 0) ? 1 : blk_tokens;
        len  = seq_live[sid] ? seq_tokens[sid] : 0;
        cnt  = seq_live[sid] ? seq_blocks[sid] : 0;
        phys = 0;
        case (op)
            OP_APPEND: begin
                need = !seq_live[sid] || cnt == 0 || (len % bs) == 0;
                if (len >= 32767 || (need && cnt >= MAXB))
                    return pack_answer(ST_TABLE_FULL, 0, len, cnt);
                if (need) begin
                    if (pool_top == 0)
                        return pack_answer(ST_NO_BLOCKS, 0, len, cnt);
                    pool_top--;
                    phys = pool_stack[pool_top];
                    seq_table[sid][cnt] = PHYS_W'(phys);
                    cnt++;
                end
                len++;
                seq_live[sid]   = 1'b1;
                seq_tokens[sid] = len;
                seq_blocks[sid] = cnt;
                return pack_answer(ST_OK, phys, len, cnt);
            end
            OP_FREE: begin
                if (!seq_live[sid])
                    return pack_answer(ST_NO_SEQ, 0, 0, 0);
                for (int k = 0; k < cnt; k++) begin
                    if (pool_top < NBLK) begin
                        pool_stack[pool_top] = seq_table[sid][k];
                        pool_top++;
                    end
                end
                seq_live[sid]   = 1'b0;
                seq_tokens[sid] = 0;
                seq_blocks[sid] = 0;
                return pack_answer(ST_OK, 0, 0, 0);
            end
            OP_LOOKUP: begin
                if (!seq_live[sid])
                    return pack_answer(ST_NO_SEQ, 0, 0, 0);
                if (lb >= cnt)
                    return pack_answer(ST_PAST_END, 0, len, cnt);
                return pack_answer(ST_OK, seq_table[sid][lb], len, cnt);
            end
            default: return pack_answer(ST_OK, 0, len, cnt);
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Results cannot be held off, so sample every done strobe
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, 0);
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_physical_block !== want.phys)
                    report_mismatch("physical_block", o_physical_block, want.phys);
                if (o_tokens_in_sequence !== want.tokens)
                    report_mismatch("tokens_in_sequence", o_tokens_in_sequence, want.tokens);
                if (o_blocks_in_sequence !== want.blocks)
                    report_mismatch("blocks_in_sequence", o_blocks_in_sequence, want.blocks);
                if (o_free_blocks !== want.free_cnt)
                    report_mismatch("free_blocks", o_free_blocks, want.free_cnt);
            end
        end
    end

    // Start stays high after the accept edge; busy blocks a second accept until
    // the next request or drain_results drops it.
    task automatic send_request(t_op op, int unsigned sid, int unsigned lb);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_op            <= op;
        i_sequence_id   <= SID_W'(sid);
        i_logical_block <= LB_W'(lb);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        answers_due.insert(answers_due.size(), predict_request(op, sid, lb));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_tokens_per_block(int unsigned bs);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= BSIZE_W'(bs);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        blk_tokens = bs;
    endtask

    task automatic free_all();
        for (int s = 0; s < NSEQ; s++)
            if (seq_live[s]) send_request(OP_FREE, s, 0);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        send_request(OP_LOOKUP, 5, 0);
        send_request(OP_FREE, 5, 0);
        send_request(OP_NONE, 63, 63);
        send_request(OP_APPEND, 0, 0);
        send_request(OP_APPEND, 0, 0);
        send_request(OP_LOOKUP, 0, 0);
        send_request(OP_LOOKUP, 0, 1);
        send_request(OP_LOOKUP, 0, 63);
        send_request(OP_APPEND, 63, 42);
        send_request(OP_NONE, 0, 21);
        send_request(OP_FREE, 0, 0);
        send_request(OP_LOOKUP, 0, 0);
        send_request(OP_APPEND, 1, 0);
        send_request(OP_FREE, 63, 0);
        send_request(OP_FREE, 1, 0);
    endtask

    // Block size 1 fills tables fast: drain the pool dry, then hit a full table
    task automatic test_exhaust_pool();
        write_tokens_per_block(1);
        for (int s = 0; s < 16; s++) begin
            idle_pct = (s < 6) ? 0 : ((s < 11) ? 86 : 37);
            for (int k = 0; k < MAXB; k++)
                send_request(OP_APPEND, s, 0);
        end
        idle_pct = 0;
        send_request(OP_APPEND, 16, 0);
        send_request(OP_APPEND, 0, 0);
        send_request(OP_LOOKUP, 16, 63);
        send_request(OP_APPEND, 40, 0);
        send_request(OP_LOOKUP, 40, 0);
        send_request(OP_FREE, 3, 0);
        for (int k = 0; k < 3; k++)
            send_request(OP_APPEND, 20, 0);
        free_all();
    endtask

    task automatic test_random(int unsigned n, int unsigned pct, int unsigned bs);
        int unsigned pick;
        int unsigned sid;
        write_tokens_per_block(bs);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            sid  = $urandom_range(7) + 8 * $urandom_range(1, 0) * $urandom_range(7);
            if (pick < 60)
                send_request(OP_APPEND, sid, $urandom_range(63));
            else if (pick < 82)
                send_request(OP_LOOKUP, sid,
                             $urandom_range(1) ? $urandom_range(3) : $urandom_range(63));
            else if (pick < 94)
                send_request(OP_FREE, sid, $urandom_range(63));
            else
                send_request(t_op'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
        end
    endtask

    initial begin
        errors      = 0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        start       = 1'b0;
        i_op        = OP_APPEND;
        i_sequence_id   = '0;
        i_logical_block = '0;
        for (int k = 0; k < NBLK; k++) pool_stack[k] = PHYS_W'(NBLK - 1 - k);
        pool_top = NBLK;
        for (int s = 0; s < NSEQ; s++) begin
            seq_live[s]   = 1'b0;
            seq_tokens[s] = 0;
            seq_blocks[s] = 0;
        end
        blk_tokens = 16;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_exhaust_pool();
        test_random(25, 0, 2);
        test_random(20, 86, 256);
        test_random(20, 37, 0);
        test_random(10, 0, 3);
        free_all();
        test_random(10, 37, 16);
        drain_results();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: paged_block_table_manager_top.f
hw/rtl/pbtm_pkg.sv
hw/rtl/paged_block_table_manager_top.sv
hw/rtl/pbtm_checker.sv
test/testbench.sv
